[rtl/osf_pkg.sv]
// shared types, constants and state codes of the overlapping site filter
package osf_pkg;

	localparam int MAX_SITES = 64;
	localparam int IDX_W     = $clog2(MAX_SITES);
	localparam int CNT_W     = $clog2(MAX_SITES + 1);
	localparam int POS_W     = 20;
	localparam int SCORE_W   = 16;
	localparam int RANK_W    = 4;
	localparam int GAP_W     = 8;
	localparam int CMD_W     = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 8;

	// command codes
	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAP  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'd1;

	// filter modes
	localparam logic MODE_SCORE = 1'b0;
	localparam logic MODE_RANK  = 1'b1;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [POS_W-1:0]   target_position;
		logic [POS_W-1:0]   site_position;
		logic [SCORE_W-1:0] align_score;
		logic [RANK_W-1:0]  seed_rank;
		logic               effective_in;
	} in_word_t;

	typedef struct packed {
		logic [IDX_W-1:0] site_index;
		logic             effective_out;
		logic             last_site;
	} out_word_t;

	typedef struct packed {
		logic [POS_W-1:0]   target_pos;
		logic [POS_W-1:0]   site_pos;
		logic [SCORE_W-1:0] score;
		logic [RANK_W-1:0]  rank;
		logic               eff;
	} site_t;

	typedef struct packed {
		logic prev_eff;
		logic cur_eff;
	} flags_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RK_RDI,
		ST_RK_GETI,
		ST_RK_RDJ,
		ST_RK_CMPJ,
		ST_RK_WRO,
		ST_WK_RDO,
		ST_WK_RDT,
		ST_WK_PROC,
		ST_WK_LAST,
		ST_EM_RD,
		ST_EM_DATA,
		ST_EM_HOLD
	} state_t;

endpackage

[rtl/osf_resolve.sv]
// overlap test and flag resolution for one pair of sorted neighbours
module osf_resolve (
	input  logic                     has_prev,
	input  osf_pkg::site_t           prev,
	input  osf_pkg::site_t           cur,
	input  logic [osf_pkg::GAP_W-1:0] gap_length,
	input  logic                     filter_mode,
	output osf_pkg::flags_t          flags
);
	import osf_pkg::*;

	logic [POS_W-1:0] diff;
	logic             is_pair;

	assign diff = cur.site_pos - prev.site_pos;
	assign is_pair = has_prev && (prev.target_pos == cur.target_pos)
		&& (prev.site_pos != '0) && (diff <= POS_W'(gap_length));

	always_comb begin
		flags.prev_eff = prev.eff;
		flags.cur_eff  = cur.eff;
		if (is_pair) begin
			if (filter_mode == MODE_SCORE) begin
				// skip when either side already dropped, later site loses ties
				if (prev.eff && cur.eff) begin
					if (prev.score < cur.score) flags.prev_eff = 1'b0;
					else                        flags.cur_eff  = 1'b0;
				end
			end else begin
				// worse rank loses, earlier site loses ties
				if (prev.rank < cur.rank) flags.cur_eff  = 1'b0;
				else                      flags.prev_eff = 1'b0;
			end
		end
	end

endmodule

[rtl/overlapping_site_filter.sv]
// top level of the overlapping site filter: site table, sort, pair walk and emission
//
// A load word (command 0) writes one site into the next free table entry;
// loads beyond 64 sites are dropped. A clear word (command 2) empties the
// table. A run word (command 1) ranks the effective sites by (target
// position, site position, load order), walks them in that order resolving
// overlapping neighbours, writes the final flags back into the table and
// then emits one word per loaded site in load order. The run is bound by
// the single read port of the site table: ranking reads every entry once
// per effective site, the walk reads the sorted order and then the table
// for each effective site, and emission reads the table once per result word.
// No input word is taken while a run is in progress.
// Configuration writes are taken at any time but belong between runs.
module overlapping_site_filter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  osf_pkg::in_word_t                 in_word,
	output logic                              out_valid,
	input  logic                              out_stall,
	output osf_pkg::out_word_t                out_word,
	input  logic                              cfg_we,
	input  logic [osf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [osf_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import osf_pkg::*;

	// site table and sorted order memories
	site_t            tab_mem [MAX_SITES];
	logic [IDX_W-1:0] ord_mem [MAX_SITES];

	logic             tab_we, tab_re;
	logic [IDX_W-1:0] tab_wa, tab_ra;
	site_t            tab_wd, tab_rd_q;
	logic             ord_we, ord_re;
	logic [IDX_W-1:0] ord_wa, ord_ra, ord_rd_q;

	// control
	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] i_q, i_d, j_q, j_d, m_q, m_d, rank_q, rank_d;
	logic [CNT_W-1:0] k_q, k_d, e_q, e_d;
	logic [GAP_W-1:0] gap_q;
	logic             mode_q;

	// site under ranking and previous site of the walk
	site_t            ki_q, ki_d;
	site_t            prev_q, prev_d;
	logic [IDX_W-1:0] prev_idx_q, prev_idx_d;

	// output register
	logic             out_valid_q, out_valid_d;
	out_word_t        out_q, out_d;

	logic             in_acc;
	logic             key_less;
	flags_t           flags;
	site_t            cur_site;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	always_ff @(posedge clk) begin
		if (tab_we) tab_mem[tab_wa] <= tab_wd;
		if (tab_re) tab_rd_q <= tab_mem[tab_ra];
		if (ord_we) ord_mem[ord_wa] <= i_q[IDX_W-1:0];
		if (ord_re) ord_rd_q <= ord_mem[ord_ra];
	end

	// current walk site carries its flag from the table
	assign cur_site = tab_rd_q;

	osf_resolve u_resolve (
		.has_prev    (k_q != '0),
		.prev        (prev_q),
		.cur         (cur_site),
		.gap_length  (gap_q),
		.filter_mode (mode_q),
		.flags       (flags)
	);

	// sort key order: target, then site position, then load order
	always_comb begin
		if (tab_rd_q.target_pos != ki_q.target_pos)
			key_less = tab_rd_q.target_pos < ki_q.target_pos;
		else if (tab_rd_q.site_pos != ki_q.site_pos)
			key_less = tab_rd_q.site_pos < ki_q.site_pos;
		else
			key_less = j_q < i_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			gap_q       <= '0;
			mode_q      <= MODE_SCORE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GAP:  gap_q  <= cfg_data;
					REG_MODE: mode_q <= cfg_data[0];
					default:  ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		i_q        <= i_d;
		j_q        <= j_d;
		m_q        <= m_d;
		rank_q     <= rank_d;
		k_q        <= k_d;
		e_q        <= e_d;
		ki_q       <= ki_d;
		prev_q     <= prev_d;
		prev_idx_q <= prev_idx_d;
		out_q      <= out_d;
	end

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		i_d         = i_q;
		j_d         = j_q;
		m_d         = m_q;
		rank_d      = rank_q;
		k_d         = k_q;
		e_d         = e_q;
		ki_d        = ki_q;
		prev_d      = prev_q;
		prev_idx_d  = prev_idx_q;
		out_valid_d = out_valid_q;
		out_d       = out_q;
		tab_we      = 1'b0;
		tab_wa      = count_q[IDX_W-1:0];
		tab_wd      = '{target_pos: in_word.target_position,
			site_pos: in_word.site_position, score: in_word.align_score,
			rank: in_word.seed_rank, eff: in_word.effective_in};
		tab_re      = 1'b0;
		tab_ra      = i_q[IDX_W-1:0];
		ord_we      = 1'b0;
		ord_wa      = rank_q[IDX_W-1:0];
		ord_re      = 1'b0;
		ord_ra      = k_q[IDX_W-1:0];

		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (in_word.command)
						CMD_LOAD: begin
							if (count_q < CNT_W'(MAX_SITES)) begin
								tab_we  = 1'b1;
								count_d = count_q + 1'b1;
							end
						end
						CMD_RUN: begin
							i_d = '0;
							m_d = '0;
							if (count_q != '0) state_d = ST_RK_RDI;
						end
						CMD_CLEAR: count_d = '0;
						default: ;
					endcase
				end
			end
			// ranking: position of site i among the effective sites
			ST_RK_RDI: begin
				tab_re  = 1'b1;
				state_d = ST_RK_GETI;
			end
			ST_RK_GETI: begin
				ki_d = tab_rd_q;
				if (!tab_rd_q.eff) begin
					i_d = i_q + 1'b1;
					if (i_q + 1'b1 == count_q) begin
						k_d     = '0;
						state_d = (m_q == '0) ? ST_EM_RD : ST_WK_RDO;
						e_d     = '0;
					end else begin
						state_d = ST_RK_RDI;
					end
				end else begin
					j_d     = '0;
					rank_d  = '0;
					state_d = ST_RK_RDJ;
				end
			end
			ST_RK_RDJ: begin
				tab_re  = 1'b1;
				tab_ra  = j_q[IDX_W-1:0];
				state_d = ST_RK_CMPJ;
			end
			ST_RK_CMPJ: begin
				if (tab_rd_q.eff && key_less) rank_d = rank_q + 1'b1;
				j_d     = j_q + 1'b1;
				state_d = (j_q + 1'b1 == count_q) ? ST_RK_WRO : ST_RK_RDJ;
			end
			ST_RK_WRO: begin
				ord_we = 1'b1;
				m_d    = m_q + 1'b1;
				i_d    = i_q + 1'b1;
				if (i_q + 1'b1 == count_q) begin
					k_d     = '0;
					state_d = ST_WK_RDO;
				end else begin
					state_d = ST_RK_RDI;
				end
			end
			// walk in sorted order, resolving each neighbour pair
			ST_WK_RDO: begin
				ord_re  = 1'b1;
				state_d = ST_WK_RDT;
			end
			ST_WK_RDT: begin
				tab_re  = 1'b1;
				tab_ra  = ord_rd_q;
				state_d = ST_WK_PROC;
			end
			ST_WK_PROC: begin
				if (k_q != '0) begin
					// previous site is final once its pair is resolved
					tab_we     = 1'b1;
					tab_wa     = prev_idx_q;
					tab_wd     = prev_q;
					tab_wd.eff = flags.prev_eff;
				end
				prev_d     = cur_site;
				prev_d.eff = flags.cur_eff;
				prev_idx_d = ord_rd_q;
				k_d        = k_q + 1'b1;
				state_d    = (k_q + 1'b1 == m_q) ? ST_WK_LAST : ST_WK_RDO;
			end
			ST_WK_LAST: begin
				tab_we  = 1'b1;
				tab_wa  = prev_idx_q;
				tab_wd  = prev_q;
				e_d     = '0;
				state_d = ST_EM_RD;
			end
			// emit one word per loaded site in load order
			ST_EM_RD: begin
				tab_re  = 1'b1;
				tab_ra  = e_q[IDX_W-1:0];
				state_d = ST_EM_DATA;
			end
			ST_EM_DATA: begin
				out_d.site_index    = e_q[IDX_W-1:0];
				out_d.effective_out = tab_rd_q.eff;
				out_d.last_site     = (e_q + 1'b1 == count_q);
				out_valid_d         = 1'b1;
				state_d             = ST_EM_HOLD;
			end
			ST_EM_HOLD: begin
				if (!out_stall) begin
					out_valid_d = 1'b0;
					e_d         = e_q + 1'b1;
					state_d     = (e_q + 1'b1 == count_q) ? ST_IDLE : ST_EM_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
